@@ hw/rtl/ldvg_pkg.sv @@
// Package for the lagged-difference velocity gate: constants, types and step functions.
`timescale 1ns / 1ps
package ldvg_pkg;

   localparam int HistDepth   = 10;
   localparam int SlotW       = $clog2(HistDepth);
   localparam int DivW        = 52;
   localparam int DivCntW     = $clog2(DivW + 1);
   localparam int CordicSteps = 30;
   localparam int StepW       = $clog2(CordicSteps + 1);
   localparam int CordW       = 46;
   localparam int LimW        = 31;

   localparam logic [19:0] UsecPerSec = 20'd1000000;
   localparam logic [31:0] HalfPiQ30  = 32'd1686629713;

   localparam logic [1:0] REG_LIMIT_SPEED_X = 2'd0;
   localparam logic [1:0] REG_LIMIT_SPEED_Y = 2'd1;
   localparam logic [1:0] REG_LIMIT_TURN    = 2'd2;

   typedef struct packed {
      logic [31:0] rem;
      logic        qbit;
   } div_step_type;

   // One restoring division step: bring in the next numerator bit, subtract if it fits.
   function automatic div_step_type div_step(input logic [31:0] rem, input logic nbit,
                                             input logic [31:0] den);
      logic [32:0]  trial;
      div_step_type res;
      trial = {rem, nbit};
      if (trial >= {1'b0, den}) begin
         res.rem  = 32'(trial - {1'b0, den});
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[31:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   // atan(2^-i) in Q2.30: table for the first eleven steps, 2^(30-i) after that.
   function automatic logic [31:0] atan_step(input logic [StepW-1:0] i);
      logic [31:0] val;
      case (i)
         5'd0:    val = 32'd843314856;
         5'd1:    val = 32'd497837829;
         5'd2:    val = 32'd263043836;
         5'd3:    val = 32'd133525158;
         5'd4:    val = 32'd67021686;
         5'd5:    val = 32'd33543515;
         5'd6:    val = 32'd16775850;
         5'd7:    val = 32'd8388437;
         5'd8:    val = 32'd4194282;
         5'd9:    val = 32'd2097149;
         5'd10:   val = 32'd1048575;
         default: val = 32'd1 << (5'd30 - i);
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/lagged_difference_velocity_gate.sv @@
// Top level of the lagged-difference velocity gate.
// Each item passes normalization, CORDIC vectoring and the divider in turn before the result beat;
// zero dx or dy skips normalization and CORDIC, and zero dt goes straight to the result.
// Items do not overlap: the next beat is taken only after the result beat has been registered;
// the first item fills the ten-entry history, gives no beat and then frees the input.
// Reset is synchronous and active high; it clears the control state and loads the limits.
`timescale 1ns / 1ps
module lagged_difference_velocity_gate
   import ldvg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // pos_x [31:0], pos_y [63:32], stamp_us [95:64], turn_cmd_zero [96], zero fill above
   input  wire logic [103:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // speed_x [31:0], speed_y [63:32], turn_term [95:64], zero_interval [96], zero fill above
   output logic [103:0]       rsp_tdata,
   input  wire logic          csr_wr_en,
   input  wire logic [1:0]    csr_addr,
   input  wire logic [30:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_DIFF, ST_MUL, ST_NORM, ST_CORDIC, ST_TMUL, ST_DIV, ST_OUT
   } state_type;

   state_type         state_ff;
   logic              primed_ff;
   logic [SlotW-1:0]  slot_ff;
   logic [SlotW-1:0]  fill_ff;
   logic [LimW-1:0]   lim_x_ff, lim_y_ff, lim_t_ff;

   logic [95:0]       hist_mem [HistDepth];
   logic [95:0]       cap_ff;
   logic              cap_tz_ff;
   logic [95:0]       old_ff;

   logic [32:0]       mag_x_ff, mag_y_ff;
   logic              neg_x_ff, neg_y_ff, zero_x_ff, zero_y_ff;
   logic [31:0]       dt_ff;

   logic signed [CordW-1:0] cx_ff, cy_ff;
   logic signed [32:0]      z_ff;
   logic [StepW-1:0]        step_ff;
   logic signed [32:0]      angle_ff;

   logic [DivW-1:0]   nx_ff, ny_ff, nt_ff;
   logic [31:0]       rx_ff, ry_ff, rt_ff;
   logic [DivCntW-1:0] dcnt_ff;
   logic              tneg_ff;

   logic [32:0]       dx_in, dy_in;
   logic [31:0]       dt_in;
   logic [DivW-1:0]   prod_x_in, prod_y_in;
   logic [31:0]       amag_in;
   logic [51:0]       prod_t_in;
   logic signed [CordW-1:0] xs_in, ys_in;
   logic signed [32:0]      zfin_in;
   div_step_type      sx_in, sy_in, st_in;
   logic [31:0]       gx_in, gy_in, gt_in;
   logic              rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_tvalid || rsp_tready;

   assign dx_in = 33'({cap_ff[31], cap_ff[31:0]} - {old_ff[31], old_ff[31:0]});
   assign dy_in = 33'({cap_ff[63], cap_ff[63:32]} - {old_ff[63], old_ff[63:32]});
   assign dt_in = cap_ff[95:64] - old_ff[95:64];

   assign prod_x_in = DivW'(mag_x_ff) * DivW'(UsecPerSec);
   assign prod_y_in = DivW'(mag_y_ff) * DivW'(UsecPerSec);
   assign amag_in   = angle_ff[32] ? 32'(-angle_ff) : angle_ff[31:0];
   assign prod_t_in = DivW'(amag_in) * DivW'(UsecPerSec);

   assign xs_in   = cx_ff >>> step_ff;
   assign ys_in   = cy_ff >>> step_ff;
   assign zfin_in = (neg_x_ff != neg_y_ff) ? -z_ff : z_ff;

   assign sx_in = div_step(rx_ff, nx_ff[DivW-1], dt_ff);
   assign sy_in = div_step(ry_ff, ny_ff[DivW-1], dt_ff);
   assign st_in = div_step(rt_ff, nt_ff[DivW-1], dt_ff);

   // After the divide the numerator registers hold the quotient magnitudes.
   assign gx_in = (nx_ff > DivW'(lim_x_ff)) ? 32'd0 :
                  (neg_x_ff ? 32'(-nx_ff) : nx_ff[31:0]);
   assign gy_in = (ny_ff > DivW'(lim_y_ff)) ? 32'd0 :
                  (neg_y_ff ? 32'(-ny_ff) : ny_ff[31:0]);
   assign gt_in = (cap_tz_ff || nt_ff > DivW'(lim_t_ff)) ? 32'd0 :
                  (tneg_ff ? 32'(-nt_ff) : nt_ff[31:0]);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cap_ff    <= req_tdata[95:0];
         cap_tz_ff <= req_tdata[96];
         old_ff    <= hist_mem[slot_ff];
      end
      if (state_ff == ST_FILL) begin
         hist_mem[fill_ff] <= cap_ff;
      end else if (state_ff == ST_DIFF) begin
         hist_mem[slot_ff] <= cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         primed_ff  <= 1'b0;
         slot_ff    <= '0;
         fill_ff    <= '0;
         rsp_tvalid <= 1'b0;
         lim_x_ff   <= LimW'(32768);
         lim_y_ff   <= LimW'(13107);
         lim_t_ff   <= LimW'(32768);
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               REG_LIMIT_SPEED_X: lim_x_ff <= csr_wdata;
               REG_LIMIT_SPEED_Y: lim_y_ff <= csr_wdata;
               REG_LIMIT_TURN:    lim_t_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_tvalid <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  fill_ff  <= '0;
                  state_ff <= primed_ff ? ST_DIFF : ST_FILL;
               end
            end
            ST_FILL: begin
               if (fill_ff == SlotW'(HistDepth - 1)) begin
                  primed_ff <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
            ST_DIFF: begin
               mag_x_ff  <= dx_in[32] ? 33'(-dx_in) : dx_in;
               mag_y_ff  <= dy_in[32] ? 33'(-dy_in) : dy_in;
               neg_x_ff  <= dx_in[32];
               neg_y_ff  <= dy_in[32];
               zero_x_ff <= (dx_in == '0);
               zero_y_ff <= (dy_in == '0);
               dt_ff     <= dt_in;
               slot_ff   <= (slot_ff == SlotW'(HistDepth - 1)) ? '0 : slot_ff + 1'b1;
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               nx_ff <= prod_x_in;
               ny_ff <= prod_y_in;
               cx_ff <= CordW'(mag_x_ff);
               cy_ff <= CordW'(mag_y_ff);
               z_ff  <= '0;
               step_ff <= '0;
               if (dt_ff == '0) begin
                  state_ff <= ST_OUT;
               end else if (zero_y_ff) begin
                  angle_ff <= '0;
                  state_ff <= ST_TMUL;
               end else if (zero_x_ff) begin
                  angle_ff <= neg_y_ff ? -33'(HalfPiQ30) : 33'(HalfPiQ30);
                  state_ff <= ST_TMUL;
               end else begin
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               // Shift both up until one reaches 2^40; jump by eight while both fit 32 bits.
               if (cx_ff < (CordW'(1) <<< 40) && cy_ff < (CordW'(1) <<< 40)) begin
                  if (cx_ff < (CordW'(1) <<< 32) && cy_ff < (CordW'(1) <<< 32)) begin
                     cx_ff <= cx_ff <<< 8;
                     cy_ff <= cy_ff <<< 8;
                  end else begin
                     cx_ff <= cx_ff <<< 1;
                     cy_ff <= cy_ff <<< 1;
                  end
               end else begin
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (step_ff == StepW'(CordicSteps)) begin
                  angle_ff <= zfin_in;
                  state_ff <= ST_TMUL;
               end else begin
                  if (!cy_ff[CordW-1]) begin
                     cx_ff <= cx_ff + ys_in;
                     cy_ff <= cy_ff - xs_in;
                     z_ff  <= z_ff + 33'(atan_step(step_ff));
                  end else begin
                     cx_ff <= cx_ff - ys_in;
                     cy_ff <= cy_ff + xs_in;
                     z_ff  <= z_ff - 33'(atan_step(step_ff));
                  end
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_TMUL: begin
               // Dividing by dt*2^14 equals dividing the floored quotient by 2^14 by dt.
               nt_ff    <= DivW'(prod_t_in[51:14]);
               tneg_ff  <= angle_ff[32];
               rx_ff    <= '0;
               ry_ff    <= '0;
               rt_ff    <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (dcnt_ff == DivCntW'(DivW)) begin
                  state_ff <= ST_OUT;
               end else begin
                  rx_ff   <= sx_in.rem;
                  ry_ff   <= sy_in.rem;
                  rt_ff   <= st_in.rem;
                  nx_ff   <= {nx_ff[DivW-2:0], sx_in.qbit};
                  ny_ff   <= {ny_ff[DivW-2:0], sy_in.qbit};
                  nt_ff   <= {nt_ff[DivW-2:0], st_in.qbit};
                  dcnt_ff <= dcnt_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  if (dt_ff == '0) begin
                     rsp_tdata <= {7'd0, 1'b1, 96'd0};
                  end else begin
                     rsp_tdata <= {7'd0, 1'b0, gt_in, gy_in, gx_in};
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ dv/ldvg_checker.sv @@
// Checker for the velocity gate: predicts each result from the accepted beats and compares.
`timescale 1ns / 1ps
module ldvg_checker
   import ldvg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [103:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [103:0] rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [30:0]  csr_wdata,
   output int                fail_count,
   output int                pending
);

   typedef struct {
      logic [31:0] speed_x;
      logic [31:0] speed_y;
      logic [31:0] turn_term;
      logic        zero_interval;
   } velocity_type;

   velocity_type velocity_q[$];
   logic [30:0] lim_speed_x, lim_speed_y, lim_turn;
   logic        primed;
   int          slot;
   logic [31:0] past_x[HistDepth];
   logic [31:0] past_y[HistDepth];
   logic [31:0] past_stamp[HistDepth];

   function automatic logic [31:0] gated(bit neg, longint unsigned mag, logic [30:0] lim);
      if (mag > longint'(lim)) return 32'd0;
      return neg ? 32'(-mag) : 32'(mag);
   endfunction

   function automatic longint unsigned atan_q30_entry(int i);
      longint unsigned tbl[11] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                  33543515, 16775850, 8388437, 4194282, 2097149, 1048575};
      if (i < 11) return tbl[i];
      return 64'd1 << (30 - i);
   endfunction

   // First-quadrant angle in Q2.30, operands normalized up to 2^40 before vectoring.
   function automatic longint heading_q30(longint unsigned ax, longint unsigned ay);
      longint x, y, z, step, xs, ys;
      z = 0;
      while (ax < (64'd1 << 40) && ay < (64'd1 << 40)) begin
         ax = ax << 1;
         ay = ay << 1;
      end
      x = ax;
      y = ay;
      for (int i = 0; i < CordicSteps; i++) begin
         step = longint'(atan_q30_entry(i));
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += step;
         end else begin
            x -= ys; y += xs; z -= step;
         end
      end
      return z;
   endfunction

   task automatic predict_velocity(logic [103:0] d);
      logic [31:0]     px, py, ts, dt32;
      logic            turn_zero;
      longint          dx, dy, angle;
      longint unsigned adx, ady, dt;
      velocity_type    v;
      px = d[31:0];
      py = d[63:32];
      ts = d[95:64];
      turn_zero = d[96];
      if (!primed) begin
         for (int i = 0; i < HistDepth; i++) begin
            past_x[i] = px; past_y[i] = py; past_stamp[i] = ts;
         end
         primed = 1'b1;
         return;
      end
      dx = longint'(signed'(px)) - longint'(signed'(past_x[slot]));
      dy = longint'(signed'(py)) - longint'(signed'(past_y[slot]));
      dt32 = ts - past_stamp[slot];
      dt = dt32;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (dt == 0) begin
         v = '{32'd0, 32'd0, 32'd0, 1'b1};
      end else begin
         v.speed_x = gated(dx < 0, adx * 1000000 / dt, lim_speed_x);
         v.speed_y = gated(dy < 0, ady * 1000000 / dt, lim_speed_y);
         if (dy == 0) angle = 0;
         else if (dx == 0) angle = dy > 0 ? longint'(HalfPiQ30) : -longint'(HalfPiQ30);
         else begin
            angle = heading_q30(adx, ady);
            if ((dx < 0) != (dy < 0)) angle = -angle;
         end
         if (turn_zero) v.turn_term = 32'd0;
         else v.turn_term = gated(angle < 0, (angle < 0 ? -angle : angle) * 1000000 / (dt << 14),
                                 lim_turn);
         v.zero_interval = 1'b0;
      end
      velocity_q.push_back(v);
      past_x[slot] = px; past_y[slot] = py; past_stamp[slot] = ts;
      slot = (slot + 1) % HistDepth;
   endtask

   task automatic compare_velocity(logic [103:0] d);
      velocity_type v;
      if (velocity_q.size() == 0) begin
         $error("result beat with nothing expected: %h", d);
         fail_count++;
         return;
      end
      v = velocity_q.pop_front();
      if (d[31:0] !== v.speed_x) begin
         $error("speed_x expected %h actual %h", v.speed_x, d[31:0]); fail_count++;
      end
      if (d[63:32] !== v.speed_y) begin
         $error("speed_y expected %h actual %h", v.speed_y, d[63:32]); fail_count++;
      end
      if (d[95:64] !== v.turn_term) begin
         $error("turn_term expected %h actual %h", v.turn_term, d[95:64]); fail_count++;
      end
      if (d[96] !== v.zero_interval) begin
         $error("zero_interval expected %b actual %b", v.zero_interval, d[96]); fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lim_speed_x = 31'd32768;
         lim_speed_y = 31'd13107;
         lim_turn    = 31'd32768;
         primed = 1'b0;
         slot = 0;
         fail_count = 0;
         velocity_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               REG_LIMIT_SPEED_X: lim_speed_x = csr_wdata;
               REG_LIMIT_SPEED_Y: lim_speed_y = csr_wdata;
               REG_LIMIT_TURN:    lim_turn = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_velocity(req_tdata);
         if (rsp_tvalid && rsp_tready) compare_velocity(rsp_tdata);
      end
      pending = velocity_q.size();
   end

endmodule

@@ dv/lagged_difference_velocity_gate_test.sv @@
// Testbench top for the velocity gate: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module lagged_difference_velocity_gate_test
   import ldvg_pkg::*;
;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int CycleLimit = 900000;

   typedef enum int {
      M_SMOOTH, M_DX_ZERO, M_DY_ZERO, M_BOTH_ZERO, M_DT_ZERO, M_EXTREME, M_WRAP, M_NOISE
   } pose_kind_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_wr_en;
   logic [1:0]   csr_addr;
   logic [30:0]  csr_wdata;
   int           fail_count, pending, cycles, burst_left;
   logic [31:0]  sent_x[$], sent_y[$], sent_stamp[$];

   lagged_difference_velocity_gate i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_addr, .csr_wdata
   );

   ldvg_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_addr, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver: stall pattern is redrawn periodically from four styles, plus one long hold-off.
   initial begin
      int n, style;
      n = 0;
      style = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         n++;
         if (n % 300 == 0) style = $urandom_range(0, 3);
         if (n > 3000 && n < 5500) rsp_tready <= 1'b0;
         else case (style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic logic [31:0] nudge(logic [31:0] v);
      int unsigned span;
      case ($urandom_range(0, 2))
         0: span = 2000;
         1: span = 70000;
         default: span = 1 << 20;
      endcase
      return v + $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [103:0] make_pose(pose_kind_type kind);
      int          back, last;
      logic [31:0] x, y, ts;
      back = sent_x.size() >= 10 ? sent_x.size() - 10 : 0;
      last = sent_x.size() - 1;
      if (last < 0) begin
         x = $urandom; y = $urandom; ts = $urandom;
      end else begin
         x = nudge(sent_x[last]);
         y = nudge(sent_y[last]);
         ts = sent_stamp[last] + $urandom_range(1, 300000);
         case (kind)
            M_DX_ZERO:   x = sent_x[back];
            M_DY_ZERO:   y = sent_y[back];
            M_BOTH_ZERO: begin x = sent_x[back]; y = sent_y[back]; end
            M_DT_ZERO:   ts = sent_stamp[back];
            M_EXTREME: begin
               x = pick_extreme(); y = pick_extreme();
               if ($urandom_range(0, 1)) ts = pick_extreme();
            end
            M_WRAP:      ts = sent_stamp[back] - $urandom_range(1, 100000);
            M_NOISE: begin x = $urandom; y = $urandom; ts = $urandom; end
            default: ;
         endcase
      end
      return {7'd0, 1'($urandom_range(0, 1)), ts, y, x};
   endfunction

   // Sender works in bursts; the valid stays high across back-to-back beats.
   task automatic send_pose(logic [103:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 150);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      sent_x.push_back(d[31:0]);
      sent_y.push_back(d[63:32]);
      sent_stamp.push_back(d[95:64]);
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_limits(logic [30:0] lx, logic [30:0] ly, logic [30:0] lt);
      csr_wr_en <= 1'b1;
      csr_addr <= REG_LIMIT_SPEED_X; csr_wdata <= lx;
      @(posedge clock);
      csr_addr <= REG_LIMIT_SPEED_Y; csr_wdata <= ly;
      @(posedge clock);
      csr_addr <= REG_LIMIT_TURN; csr_wdata <= lt;
      @(posedge clock);
      csr_addr <= REG_SPARE; csr_wdata <= 31'h7FFF_FFFF;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int count);
      int r;
      pose_kind_type kind;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 60) kind = M_SMOOTH;
         else if (r < 95) kind = pose_kind_type'($urandom_range(1, 6));
         else kind = M_NOISE;
         send_pose(make_pose(kind));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_addr = REG_LIMIT_SPEED_X;
      csr_wdata = '0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the history with extremes, then step through every pose kind at least once.
      for (int i = 0; i < 25; i++)
         send_pose(make_pose(i < 11 ? M_EXTREME : pose_kind_type'((i - 11) % 8)));
      random_phase(150);
      drain();
      write_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      random_phase(160);
      drain();
      write_limits(31'd0, 31'd0, 31'd0);
      random_phase(150);
      drain();
      write_limits(31'($urandom_range(0, 1 << 24)), 31'($urandom_range(0, 1 << 20)),
                   31'($urandom_range(0, 1 << 22)));
      random_phase(165);
      drain();

      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ldvg_pkg.sv
hw/rtl/lagged_difference_velocity_gate.sv
dv/ldvg_checker.sv
dv/lagged_difference_velocity_gate_test.sv
